[hdl/spur_pkg.sv]
// Shared types and constants for the single-pin ultrasonic ranger.
package spur_pkg;

  localparam int TPM_W     = 20;
  localparam int TRIG_W    = 10;
  localparam int TMO_W     = 24;
  localparam int DIST_W    = 16;
  localparam int MM_PER_MS = 171;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [1:0] REG_TICKS_PER_MS  = 2'd0;
  localparam logic [1:0] REG_TRIGGER_TICKS = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [TPM_W-1:0]  TPM_RESET  = TPM_W'(1000);
  localparam logic [TRIG_W-1:0] TRIG_RESET = TRIG_W'(10);
  localparam logic [TMO_W-1:0]  TMO_RESET  = TMO_W'(100000);

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  typedef enum logic {
    SQ_READY  = 1'b0,
    SQ_DIVIDE = 1'b1
  } seq_t;

  typedef enum logic [1:0] {
    DV_IDLE = 2'd0,
    DV_MUL  = 2'd1,
    DV_RUN  = 2'd2
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic kind;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic              trigger_drive;
    logic              drive_enable;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [DIST_W-1:0] range_mm;
  } out_item_t;

endpackage

[hdl/spur_chan_if.sv]
// Valid/ready item channel with source and sink modports.
interface spur_chan_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/spur_div.sv]
// Serial scale-and-divide unit: min(171 * count / divisor, 65535).
module spur_div #(
  parameter int CNT_W = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [CNT_W-1:0]           count,
  input  logic [spur_pkg::TPM_W-1:0] divisor,
  output spur_pkg::div_status_t      status,
  output logic [spur_pkg::DIST_W-1:0] quot
);
  import spur_pkg::*;

  localparam int PW = CNT_W + 8;
  localparam int SW = $clog2(PW);

  div_state_t        dstate, dstate_next;
  logic [CNT_W-1:0]  cnt_q;
  logic [TPM_W-1:0]  dvsr;
  logic [PW-1:0]     prod;
  logic [TPM_W:0]    rem;
  logic [TPM_W:0]    rem_sh;
  logic              fits;
  logic [DIST_W-1:0] q;
  logic              ovf;
  logic [SW-1:0]     step;
  logic              done;

  assign rem_sh = {rem[TPM_W-1:0], prod[PW-1]};
  assign fits   = rem_sh >= {1'b0, dvsr};

  always_comb begin
    dstate_next = dstate;
    unique case (dstate)
      DV_IDLE: if (start) dstate_next = DV_MUL;
      DV_MUL:  dstate_next = DV_RUN;
      DV_RUN:  if (step == '0) dstate_next = DV_IDLE;
      default: dstate_next = DV_IDLE;
    endcase
  end

  always_comb begin
    status.busy = dstate != DV_IDLE;
    status.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= DV_IDLE;
      done   <= 1'b0;
    end else begin
      dstate <= dstate_next;
      done   <= (dstate == DV_RUN) && (step == '0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (dstate)
      DV_IDLE: begin
        if (start) begin
          cnt_q <= count;
          dvsr  <= divisor;
        end
      end
      DV_MUL: begin
        prod <= PW'(cnt_q) * PW'(MM_PER_MS);
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        step <= SW'(PW - 1);
      end
      DV_RUN: begin
        rem  <= fits ? rem_sh - {1'b0, dvsr} : rem_sh;
        prod <= {prod[PW-2:0], 1'b0};
        q    <= {q[DIST_W-2:0], fits};
        ovf  <= ovf | q[DIST_W-1];
        step <= step - 1'b1;
        if (step == '0) begin
          if (ovf || q[DIST_W-1] || dvsr == '0) quot <= '1;
          else quot <= {q[DIST_W-2:0], fits};
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/single_pin_ultrasonic_ranger.sv]
// Top level of the single-pin ultrasonic ranger: phase control, registers, result stage.
// Each request item is a time tick or a start request and yields exactly one result item
// with the pin control, busy, done and timeout flags and the last distance. The tick that
// sees the echo fall runs 171 * high count through a serial restoring divider by
// ticks_per_ms, one quotient bit per cycle; request.ready stays low meanwhile. The result
// stage holds one item; a new item is taken when that stage is empty or being drained.
// Registers sit at byte addresses 0 (ticks_per_ms), 4 (trigger_ticks) and 8 (timeout_ticks).
module single_pin_ultrasonic_ranger #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  spur_chan_if.sink                       request,
  spur_chan_if.source                     result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spur_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [spur_pkg::APB_DATA_W-1:0] pwdata,
  output logic [spur_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import spur_pkg::*;

  localparam int CMPW = (COUNT_WIDTH > TMO_W) ? COUNT_WIDTH : TMO_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [TPM_W-1:0]  ticks_per_ms;
  logic [TRIG_W-1:0] trigger_ticks;
  logic [TMO_W-1:0]  timeout_ticks;

  phase_t                 phase, phase_next;
  seq_t                   seq, seq_next;
  logic [COUNT_WIDTH-1:0] ticks, ticks_next, ticks_inc;
  logic [COUNT_WIDTH-1:0] high, high_next, high_inc;
  logic                   last_level, level_next;
  logic [DIST_W-1:0]      last_distance;
  logic                   done_c, tmo_c;
  logic                   accept, cfg_wr;
  logic                   div_start;
  div_status_t            div_stat;
  logic [DIST_W-1:0]      div_quot;

  assign accept = request.valid && request.ready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_TICKS_PER_MS:  prdata = APB_DATA_W'(ticks_per_ms);
      REG_TRIGGER_TICKS: prdata = APB_DATA_W'(trigger_ticks);
      REG_TIMEOUT_TICKS: prdata = APB_DATA_W'(timeout_ticks);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms  <= TPM_RESET;
      trigger_ticks <= TRIG_RESET;
      timeout_ticks <= TMO_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TICKS_PER_MS:  ticks_per_ms  <= pwdata[TPM_W-1:0];
        REG_TRIGGER_TICKS: trigger_ticks <= pwdata[TRIG_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  assign ticks_inc = (ticks == CNT_MAX) ? ticks : ticks + 1'b1;
  assign high_inc  = (high == CNT_MAX) ? high : high + 1'b1;

  always_comb begin
    phase_next = phase;
    ticks_next = ticks;
    high_next  = high;
    level_next = last_level;
    done_c     = 1'b0;
    tmo_c      = 1'b0;
    if (request.data.kind == KIND_START) begin
      if (phase == PH_IDLE) begin
        phase_next = PH_TRIG;
        ticks_next = '0;
        high_next  = '0;
      end
    end else begin
      unique case (phase)
        PH_IDLE: phase_next = phase;
        PH_TRIG: begin
          ticks_next = ticks_inc;
          if (CMPW'(ticks_inc) >= CMPW'(trigger_ticks)) begin
            phase_next = PH_WAIT;
            ticks_next = '0;
            level_next = 1'b0;
          end
        end
        PH_WAIT, PH_HIGH: begin
          ticks_next = ticks_inc;
          if (phase == PH_WAIT) begin
            if (request.data.pin_level && !last_level) begin
              phase_next = PH_HIGH;
              high_next  = '0;
            end
          end else begin
            high_next = high_inc;
            if (!request.data.pin_level) begin
              done_c     = 1'b1;
              phase_next = PH_IDLE;
              ticks_next = '0;
            end
          end
          level_next = request.data.pin_level;
          if (!done_c && CMPW'(ticks_inc) >= CMPW'(timeout_ticks)) begin
            tmo_c      = 1'b1;
            phase_next = PH_IDLE;
            ticks_next = '0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_READY:  if (accept && done_c) seq_next = SQ_DIVIDE;
      SQ_DIVIDE: if (div_stat.done) seq_next = SQ_READY;
      default:   seq_next = SQ_READY;
    endcase
  end

  always_comb begin
    request.ready = (seq == SQ_READY) && (!result.valid || result.ready);
    div_start     = accept && done_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= SQ_READY;
      phase         <= PH_IDLE;
      ticks         <= '0;
      high          <= '0;
      last_level    <= 1'b0;
      last_distance <= '0;
      result.valid  <= 1'b0;
    end else begin
      seq <= seq_next;
      if (result.valid && result.ready) result.valid <= 1'b0;
      if (accept) begin
        phase      <= phase_next;
        ticks      <= ticks_next;
        high       <= high_next;
        last_level <= level_next;
        if (!done_c) result.valid <= 1'b1;
      end
      if (seq == SQ_DIVIDE && div_stat.done) begin
        last_distance <= div_quot;
        result.valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !done_c) begin
      result.data.trigger_drive <= phase_next == PH_TRIG;
      result.data.drive_enable  <= (phase_next == PH_IDLE) || (phase_next == PH_TRIG);
      result.data.busy_res      <= phase_next != PH_IDLE;
      result.data.done_res      <= 1'b0;
      result.data.timed_out     <= tmo_c;
      result.data.range_mm      <= last_distance;
    end else if (seq == SQ_DIVIDE && div_stat.done) begin
      result.data.trigger_drive <= 1'b0;
      result.data.drive_enable  <= 1'b1;
      result.data.busy_res      <= 1'b0;
      result.data.done_res      <= 1'b1;
      result.data.timed_out     <= 1'b0;
      result.data.range_mm      <= div_quot;
    end
  end

  spur_div #(
    .CNT_W(COUNT_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .count   (high_next),
    .divisor (ticks_per_ms),
    .status  (div_stat),
    .quot    (div_quot)
  );

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> seq == SQ_DIVIDE)
    else $error("divider result outside divide step");

  a_echo_to_divide: assert property (@(posedge clk) disable iff (rst)
    div_start |=> seq == SQ_DIVIDE && phase == PH_IDLE && !result.valid)
    else $error("echo end did not enter divide step");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    seq == SQ_DIVIDE |-> !result.valid && !request.ready)
    else $error("result stage busy during divide");

  a_timeout_idle: assert property (@(posedge clk) disable iff (rst)
    accept && tmo_c |=> result.valid && result.data.timed_out && phase == PH_IDLE)
    else $error("timeout did not end measurement");

endmodule

[sim/single_pin_ultrasonic_ranger_tb.sv]
// Self-checking testbench for the single-pin ultrasonic ranger: predicted readings vs. results.
`timescale 1ns / 100ps

module single_pin_ultrasonic_ranger_tb;
  import spur_pkg::*;

  localparam int CNT_W       = 24;
  localparam int STALL_LIMIT = 1000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  spur_chan_if #(.item_t(in_item_t))  req_if ();
  spur_chan_if #(.item_t(out_item_t)) res_if ();

  single_pin_ultrasonic_ranger #(.COUNT_WIDTH(CNT_W)) uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the ranger
  logic [TPM_W-1:0]  tpm_cfg;
  logic [TRIG_W-1:0] trig_cfg;
  logic [TMO_W-1:0]  tmo_cfg;
  phase_t            ph;
  logic [CNT_W-1:0]  span_cnt;
  logic [CNT_W-1:0]  echo_cnt;
  logic              prev_level;
  logic [DIST_W-1:0] dist_mm;

  out_item_t   pending_readings[$];
  int unsigned sent_items;
  int          err_cnt;
  int          idle_cycles;
  int          hold_cnt;
  bit          idle_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic out_item_t predict_reading(in_item_t it);
    out_item_t   o;
    logic        done_f;
    logic        tmo_f;
    logic [63:0] q;
    done_f = 1'b0;
    tmo_f  = 1'b0;
    if (it.kind == KIND_START) begin
      if (ph == PH_IDLE) begin
        ph       = PH_TRIG;
        span_cnt = '0;
        echo_cnt = '0;
      end
    end else if (ph == PH_TRIG) begin
      span_cnt = sat_inc(span_cnt);
      if (span_cnt >= trig_cfg) begin
        ph         = PH_WAIT;
        span_cnt   = '0;
        prev_level = 1'b0;
      end
    end else if (ph == PH_WAIT || ph == PH_HIGH) begin
      span_cnt = sat_inc(span_cnt);
      if (ph == PH_WAIT) begin
        if (it.pin_level && !prev_level) begin
          ph       = PH_HIGH;
          echo_cnt = '0;
        end
      end else begin
        echo_cnt = sat_inc(echo_cnt);
        if (!it.pin_level) begin
          if (tpm_cfg == '0) begin
            dist_mm = '1;
          end else begin
            q       = (64'(echo_cnt) * 64'(MM_PER_MS)) / 64'(tpm_cfg);
            dist_mm = (q > 64'hFFFF) ? 16'hFFFF : q[DIST_W-1:0];
          end
          done_f   = 1'b1;
          ph       = PH_IDLE;
          span_cnt = '0;
        end
      end
      prev_level = it.pin_level;
      if (!done_f && span_cnt >= tmo_cfg) begin
        tmo_f    = 1'b1;
        ph       = PH_IDLE;
        span_cnt = '0;
      end
    end
    o.trigger_drive = (ph == PH_TRIG);
    o.drive_enable  = (ph == PH_IDLE || ph == PH_TRIG);
    o.busy_res      = (ph != PH_IDLE);
    o.done_res      = done_f;
    o.timed_out     = tmo_f;
    o.range_mm      = dist_mm;
    return o;
  endfunction

  function automatic string show_reading(out_item_t r);
    return $sformatf("trig=%0b drv=%0b busy=%0b done=%0b tmo=%0b dist=%0d", r.trigger_drive,
                     r.drive_enable, r.busy_res, r.done_res, r.timed_out, r.range_mm);
  endfunction

  task automatic note_fail(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  // result check and stall watchdog
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (!rst) begin
      if (req_if.valid && req_if.ready) pending_readings.push_back(predict_reading(req_if.data));
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (pending_readings.size() == 0) begin
          note_fail({"result item with none expected: ", show_reading(got)});
        end else begin
          want = pending_readings.pop_front();
          if (got.trigger_drive !== want.trigger_drive || got.drive_enable !== want.drive_enable ||
              got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
              got.timed_out !== want.timed_out || got.range_mm !== want.range_mm) begin
            note_fail({"reading mismatch: exp ", show_reading(want), " got ", show_reading(got)});
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("single_pin_ultrasonic_ranger_tb failed");
          $finish;
        end
      end
    end
  end

  // result-side backpressure in bursts of random length
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      res_if.ready <= 1'b0;
      hold_cnt     <= $urandom_range(0, 7);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic send_item(logic kind, logic level);
    in_item_t it;
    it.kind      = kind;
    it.pin_level = level;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic settle_results();
    req_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_TICKS_PER_MS: begin
        tpm_cfg = val[TPM_W-1:0];
        stored  = 32'(tpm_cfg);
      end
      REG_TRIGGER_TICKS: begin
        trig_cfg = val[TRIG_W-1:0];
        stored   = 32'(trig_cfg);
      end
      default: begin
        tmo_cfg = val[TMO_W-1:0];
        stored  = 32'(tmo_cfg);
      end
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored) begin
      note_fail($sformatf("register %0d readback exp %0h got %0h", idx, stored, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_ranging(logic [31:0] tpm, logic [31:0] trig, logic [31:0] tmo);
    settle_results();
    write_reg(REG_TICKS_PER_MS, tpm);
    write_reg(REG_TRIGGER_TICKS, trig);
    write_reg(REG_TIMEOUT_TICKS, tmo);
  endtask

  task automatic measure_fixed(int wait_n, int high_n);
    send_item(KIND_START, 1'b0);
    repeat ((trig_cfg == 0) ? 1 : trig_cfg) send_item(KIND_TICK, 1'b1);
    repeat (wait_n) send_item(KIND_TICK, 1'b0);
    repeat (high_n) send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b0);
  endtask

  task automatic run_measurement();
    int wait_n;
    int high_n;
    wait_n = $urandom_range(0, 5);
    high_n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
    send_item(KIND_START, $urandom_range(0, 1));
    repeat ((trig_cfg == 0) ? 1 : trig_cfg) send_item(KIND_TICK, $urandom_range(0, 1));
    if (tmo_cfg <= 64 && $urandom_range(0, 5) == 0) begin
      // no echo: listen until the timeout fires
      repeat (tmo_cfg + 1) send_item(KIND_TICK, 1'b0);
    end else begin
      repeat (wait_n) send_item(KIND_TICK, $urandom_range(0, 7) == 0);
      repeat (high_n) begin
        if ($urandom_range(0, 15) == 0) send_item(KIND_START, 1'b1);
        send_item(KIND_TICK, 1'b1);
      end
      send_item(KIND_TICK, 1'b0);
    end
    repeat ($urandom_range(0, 2)) send_item($urandom_range(0, 3) == 0, $urandom_range(0, 1));
  endtask

  task automatic run_phase(logic [31:0] tpm, logic [31:0] trig, logic [31:0] tmo, int n,
                           bit idle);
    int unsigned target;
    set_ranging(tpm, trig, tmo);
    idle_on = idle;
    target  = sent_items + n;
    while (sent_items < target) run_measurement();
  endtask

  task automatic test_idle_ticks();
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b0);
  endtask

  task automatic test_basic_echo();
    set_ranging(1, 2, 20);
    send_item(KIND_START, 1'b0);
    send_item(KIND_START, 1'b1);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_START, 1'b1);
    send_item(KIND_TICK, 1'b0);
  endtask

  task automatic test_first_sample_high();
    measure_fixed(0, 1);
  endtask

  task automatic test_timeout_cases();
    set_ranging(1, 2, 3);
    send_item(KIND_START, 1'b0);
    repeat (5) send_item(KIND_TICK, 1'b0);
    // echo ends on the timeout tick
    measure_fixed(1, 1);
  endtask

  task automatic test_zero_settings();
    set_ranging(0, 0, 0);
    send_item(KIND_START, 1'b0);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_TICK, 1'b1);
    set_ranging(0, 0, 5);
    measure_fixed(0, 1);
  endtask

  task automatic test_random_ranging();
    run_phase(1, 1, 1000, 0, 1'b1);
    measure_fixed(1, 400);
    run_phase(1, 1, 30, 50, 1'b1);
    run_phase(171, 3, 25, 60, $urandom_range(0, 3) != 0);
    run_phase(1000000, 1, 24'hFFFFFF, 50, 1'b1);
    run_phase($urandom_range(2, 400), 200, 12, 1, 1'b1);
    run_phase(0, 0, $urandom_range(5, 20), 50, $urandom_range(0, 3) != 0);
  endtask

  task automatic test_final_no_idle();
    run_phase($urandom_range(1, 1000), $urandom_range(1, 4), $urandom_range(8, 40), 150, 1'b0);
  endtask

  initial begin
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tpm_cfg      = TPM_RESET;
    trig_cfg     = TRIG_RESET;
    tmo_cfg      = TMO_RESET;
    ph           = PH_IDLE;
    span_cnt     = '0;
    echo_cnt     = '0;
    prev_level   = 1'b0;
    dist_mm      = '0;
    sent_items   = 0;
    err_cnt      = 0;
    idle_cycles  = 0;
    hold_cnt     = 0;
    idle_on      = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_ticks();
    test_basic_echo();
    test_first_sample_high();
    test_timeout_cases();
    test_zero_settings();
    test_random_ranging();
    test_final_no_idle();

    settle_results();
    repeat (50) @(negedge clk);
    if (err_cnt == 0 && pending_readings.size() == 0) begin
      $display("single_pin_ultrasonic_ranger_tb passed");
    end else begin
      $display("single_pin_ultrasonic_ranger_tb failed");
    end
    $finish;
  end

endmodule

[single_pin_ultrasonic_ranger.f]
hdl/spur_pkg.sv
hdl/spur_chan_if.sv
hdl/spur_div.sv
hdl/single_pin_ultrasonic_ranger.sv
sim/single_pin_ultrasonic_ranger_tb.sv
